FILE: sv/xtkq_pkg.sv
package xtkq_pkg;

   // Trie geometry.
   localparam int KEY_BITS   = 32;
   localparam int MAX_KEYS   = 1024;
   localparam int NODE_COUNT = 1 + MAX_KEYS * KEY_BITS;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int CNT_W      = $clog2(MAX_KEYS + 1);
   localparam int LVL_W      = $clog2(KEY_BITS);

   // Fixed field widths of the request and response items.
   localparam int KEY_W   = 32;
   localparam int RANK_W  = 11;
   localparam int XOR_W   = 32;
   localparam int STAT_W  = 2;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic              req_type;
      logic [KEY_W-1:0]  key;
      logic [RANK_W-1:0] rank;
   } req_item_type;

   typedef struct packed {
      logic [XOR_W-1:0]  xor_value;
      logic [STAT_W-1:0] status;
   } rsp_item_type;

   // One trie node: both child links and the pass counts of both children.
   typedef struct packed {
      logic [NODE_W-1:0] link_zero;
      logic [NODE_W-1:0] link_one;
      logic [CNT_W-1:0]  count_zero;
      logic [CNT_W-1:0]  count_one;
   } row_type;

   // Outcome of one trie level.
   typedef struct packed {
      logic [NODE_W-1:0] next_node;
      row_type           new_row;
      logic [CNT_W-1:0]  rank_next;
      logic              result_bit;
      logic              alloc;
   } step_type;

endpackage

FILE: sv/xtkq_node_mem.sv
module xtkq_node_mem (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [xtkq_pkg::NODE_W-1:0] wr_addr,
   input  xtkq_pkg::row_type      wr_data,
   input  logic [xtkq_pkg::NODE_W-1:0] rd_addr,
   output xtkq_pkg::row_type      rd_data
);
   import xtkq_pkg::*;

   row_type node_rows [NODE_COUNT];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_rows[wr_addr] <= wr_data;
      end
      rd_data_ff <= node_rows[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/xtkq_level_unit.sv
module xtkq_level_unit (
   input  logic                        op_query,
   input  logic                        key_bit,
   input  xtkq_pkg::row_type           row,
   input  logic [xtkq_pkg::CNT_W-1:0]  rank_rem,
   input  logic [xtkq_pkg::NODE_W-1:0] next_free,
   output xtkq_pkg::step_type          step
);
   import xtkq_pkg::*;

   logic [NODE_W-1:0] same_link;
   logic [NODE_W-1:0] other_link;
   logic [CNT_W-1:0]  same_count;
   logic [CNT_W-1:0]  eff_count;
   logic              missing;

   always_comb begin
      same_link  = key_bit ? row.link_one  : row.link_zero;
      other_link = key_bit ? row.link_zero : row.link_one;
      same_count = key_bit ? row.count_one : row.count_zero;
      missing    = (same_link == '0);
      // A missing child counts as empty.
      eff_count  = missing ? '0 : same_count;

      step            = '0;
      step.new_row    = row;
      step.rank_next  = rank_rem;
      if (!op_query) begin
         // Insert: follow or allocate the child on the key bit and bump its count.
         step.alloc     = missing;
         step.next_node = missing ? next_free : same_link;
         if (key_bit) begin
            step.new_row.link_one  = step.next_node;
            step.new_row.count_one = same_count + CNT_W'(1);
         end else begin
            step.new_row.link_zero  = step.next_node;
            step.new_row.count_zero = same_count + CNT_W'(1);
         end
      end else if (eff_count < rank_rem) begin
         // Not enough keys share this bit: skip them and take the other side.
         step.rank_next  = rank_rem - eff_count;
         step.next_node  = other_link;
         step.result_bit = 1'b1;
      end else begin
         step.next_node = same_link;
      end
   end

endmodule

FILE: sv/xor_trie_kth_query_core.sv
// Binary trie that stores 32-bit keys and answers "k-th smallest XOR" queries.
//
// Requests come in on req_data and transfer at a rising edge with start high
// and busy low. An insert (req_type 0) adds the key; duplicates count twice.
// A query (req_type 1) returns the rank-th smallest XOR of its key with any
// stored key. Every request yields exactly one response on rsp_data, shown for
// a single cycle with rsp_valid high. The receiver cannot stall, so a response
// must be captured in that cycle.
//
// Timing: the walk visits one trie level per cycle through one shared level
// unit and one node memory, so a walked request keeps busy high until its
// last level is done and its response is registered from that last level; a
// new request may transfer in the response cycle.
// A request that fails at once (store full, or rank 0 or above the key count)
// answers in the next cycle.
//
// Reset clears the key count, the root node and the allocator; the node
// memory needs no clearing because a node's row is only read after it is
// written, and freshly allocated nodes are treated as empty.
module xor_trie_kth_query_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  xtkq_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   output xtkq_pkg::rsp_item_type rsp_data
);
   import xtkq_pkg::*;

   state_type         state_ff, state_in;
   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [CNT_W-1:0]  rank_rem_ff;
   logic [LVL_W-1:0]  level_ff;
   logic [NODE_W-1:0] cur_ff;
   logic              fresh_ff;
   logic [XOR_W-1:0]  xor_ff;
   logic [NODE_W-1:0] next_free_ff;
   logic [CNT_W-1:0]  stored_ff;
   row_type           root_row_ff;
   logic              rsp_valid_ff;
   rsp_item_type      rsp_data_ff;

   logic              accept;
   logic              reject_full;
   logic              reject_range;
   logic              walking;
   logic              last_level;
   logic              at_root;
   logic              mem_wr_en;
   logic              root_wr_en;
   row_type           mem_rd_row;
   row_type           cur_row;
   step_type          step;
   logic [XOR_W-1:0]  xor_in;

   // The root row lives in flops so that it reads as empty right after reset.
   assign at_root = (cur_ff == '0);

   always_comb begin
      if (at_root) begin
         cur_row = root_row_ff;
      end else if (fresh_ff) begin
         // A node allocated on the previous level has no children yet.
         cur_row = '0;
      end else begin
         cur_row = mem_rd_row;
      end
   end

   assign accept       = start && !busy;
   assign reject_full  = (req_data.req_type == REQ_INSERT) &&
                         (32'(stored_ff) >= 32'(MAX_KEYS));
   assign reject_range = (req_data.req_type == REQ_QUERY) &&
                         ((req_data.rank == '0) || (32'(req_data.rank) > 32'(stored_ff)));
   assign last_level   = (level_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !reject_full && !reject_range) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (last_level) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      busy       = 1'b0;
      walking    = 1'b0;
      mem_wr_en  = 1'b0;
      root_wr_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_WALK: begin
            busy       = 1'b1;
            walking    = 1'b1;
            mem_wr_en  = (op_ff == REQ_INSERT) && !at_root;
            root_wr_en = (op_ff == REQ_INSERT) && at_root;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   xtkq_level_unit u_level (
      .op_query  (op_ff == REQ_QUERY),
      .key_bit   (key_ff[level_ff]),
      .row       (cur_row),
      .rank_rem  (rank_rem_ff),
      .next_free (next_free_ff),
      .step      (step)
   );

   // The next level's row is fetched while this level is being written back.
   xtkq_node_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (cur_ff),
      .wr_data (step.new_row),
      .rd_addr (step.next_node),
      .rd_data (mem_rd_row)
   );

   always_comb begin
      xor_in           = xor_ff;
      xor_in[level_ff] = step.result_bit;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         next_free_ff <= NODE_W'(1);
         stored_ff    <= '0;
         root_row_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (accept && (reject_full || reject_range)) ||
                         (walking && last_level);
         if (walking && step.alloc) begin
            next_free_ff <= next_free_ff + NODE_W'(1);
         end
         if (root_wr_en) begin
            root_row_ff <= step.new_row;
         end
         if (walking && last_level && (op_ff == REQ_INSERT)) begin
            stored_ff <= stored_ff + CNT_W'(1);
         end
      end
   end

   // Walk datapath and response register.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_data.req_type;
         key_ff      <= req_data.key;
         rank_rem_ff <= CNT_W'(req_data.rank);
         level_ff    <= LVL_W'(KEY_BITS - 1);
         cur_ff      <= '0;
         fresh_ff    <= 1'b0;
         xor_ff      <= '0;
         rsp_data_ff.xor_value <= '0;
         if (reject_full) begin
            rsp_data_ff.status <= STATUS_FULL;
         end else begin
            rsp_data_ff.status <= STATUS_RANGE;
         end
      end else if (walking) begin
         level_ff    <= level_ff - LVL_W'(1);
         cur_ff      <= step.next_node;
         fresh_ff    <= step.alloc;
         rank_rem_ff <= step.rank_next;
         xor_ff      <= xor_in;
         if (last_level) begin
            rsp_data_ff.xor_value <= xor_in;
            rsp_data_ff.status    <= STATUS_OK;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A response is only shown while the core is idle.
   a_rsp_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while walking");

   // Every accepted request either starts a walk or answers at once.
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request produced neither walk nor response");

   // The allocator never runs past the end of the node memory.
   a_alloc_bound : assert property (@(posedge clock) disable iff (reset)
      32'(next_free_ff) <= 32'(NODE_COUNT))
      else $error("node allocator overflow");

   // Insert walks end with the key count bumped by one.
   a_count_bump : assert property (@(posedge clock) disable iff (reset)
      (walking && last_level && (op_ff == REQ_INSERT)) |=>
      (stored_ff == $past(stored_ff) + CNT_W'(1)))
      else $error("key count not updated after insert");

endmodule
